// ===== src/dfu_pkg.sv =====
`default_nettype none

package dfu_pkg;

	localparam int STAGE_BYTES = 262144;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_IMAGE_BYTES  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_IMAGE_BYTES  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MANIFEST_POLL_MS = 2'd2;

	localparam logic [18:0] MAX_IMAGE_RESET  = 19'd262144;
	localparam logic [18:0] MIN_IMAGE_RESET  = 19'd4096;
	localparam logic [23:0] POLL_MS_RESET    = 24'd500;

	localparam logic [2:0] OP_DETACH    = 3'd0;
	localparam logic [2:0] OP_DNLOAD    = 3'd1;
	localparam logic [2:0] OP_UPLOAD    = 3'd2;
	localparam logic [2:0] OP_GETSTATUS = 3'd3;
	localparam logic [2:0] OP_CLRSTATUS = 3'd4;
	localparam logic [2:0] OP_GETSTATE  = 3'd5;
	localparam logic [2:0] OP_ABORT     = 3'd6;
	localparam logic [2:0] OP_BUS_RESET = 3'd7;

	localparam logic [2:0] STATUS_OK       = 3'd0;
	localparam logic [2:0] STATUS_ADDRESS  = 3'd1;
	localparam logic [2:0] STATUS_NOTDONE  = 3'd2;
	localparam logic [2:0] STATUS_FIRMWARE = 3'd3;
	localparam logic [2:0] STATUS_STALLED  = 3'd4;

	localparam logic [7:0] HEADER_MAGIC = 8'hEA;

	localparam logic [2:0] REPLY_GETSTATUS = 3'd6;
	localparam logic [2:0] REPLY_GETSTATE  = 3'd1;
	localparam logic [2:0] REPLY_NONE      = 3'd0;

	typedef enum logic [3:0] {
		ST_IDLE      = 4'd2,
		ST_DN_SYNC   = 4'd3,
		ST_DN_IDLE   = 4'd5,
		ST_MAN_SYNC  = 4'd6,
		ST_MAN       = 4'd7,
		ST_MAN_WAIT  = 4'd8,
		ST_FAULT     = 4'd10
	} state_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] block_number;
		logic [15:0] payload_length;
		logic [7:0]  header_byte;
	} req_t;

	typedef struct packed {
		logic        stalled;
		logic [2:0]  reported_status;
		logic [3:0]  reported_state;
		logic [23:0] poll_timeout_ms;
		logic [2:0]  reply_bytes;
		logic        stage_write;
		logic [17:0] stage_offset;
		logic        burn_pending;
	} rsp_t;

	typedef struct packed {
		logic [18:0] max_image_bytes;
		logic [18:0] min_image_bytes;
		logic [23:0] manifest_poll_ms;
	} cfg_t;

	typedef struct packed {
		state_t      state;
		logic [2:0]  status;
		logic [18:0] staged_bytes;
		logic [18:0] next_block;
		logic        ready_flag;
		logic [7:0]  image_byte_three;
	} ctx_t;

endpackage

`default_nettype wire

// ===== src/dfu_cfg_regs.sv =====
`default_nettype none

module dfu_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [dfu_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [dfu_pkg::CFG_DATA_W-1:0]   cfg_data,
	output dfu_pkg::cfg_t                         cfg
);

	dfu_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_image_bytes  <= dfu_pkg::MAX_IMAGE_RESET;
			cfg_q.min_image_bytes  <= dfu_pkg::MIN_IMAGE_RESET;
			cfg_q.manifest_poll_ms <= dfu_pkg::POLL_MS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dfu_pkg::REG_MAX_IMAGE_BYTES: begin
					cfg_q.max_image_bytes <= cfg_data[18:0];
				end
				dfu_pkg::REG_MIN_IMAGE_BYTES: begin
					cfg_q.min_image_bytes <= cfg_data[18:0];
				end
				dfu_pkg::REG_MANIFEST_POLL_MS: begin
					cfg_q.manifest_poll_ms <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== src/dfu_step.sv =====
`default_nettype none

module dfu_step (
	input  wire dfu_pkg::ctx_t ctx,
	input  wire dfu_pkg::cfg_t cfg,
	input  wire dfu_pkg::req_t req,
	output dfu_pkg::ctx_t ctx_next,
	output dfu_pkg::rsp_t rsp
);

	logic        fresh;
	logic [18:0] staged_base;
	logic [18:0] block_base;
	logic [19:0] staged_sum;
	logic [19:0] stage_limit;
	logic        block_ok;
	logic        size_ok;
	logic        covers_header;
	logic        image_ok;

	// A download that starts from idle counts from zero.
	assign fresh       = (ctx.state == dfu_pkg::ST_IDLE);
	assign staged_base = fresh ? '0 : ctx.staged_bytes;
	assign block_base  = fresh ? '0 : ctx.next_block;
	assign staged_sum  = {1'b0, staged_base} + {4'd0, req.payload_length};
	assign stage_limit = (32'(cfg.max_image_bytes) < dfu_pkg::STAGE_BYTES)
		? {1'b0, cfg.max_image_bytes} : 20'(dfu_pkg::STAGE_BYTES);
	assign block_ok      = ({3'd0, req.block_number} == block_base);
	assign size_ok       = (staged_sum <= stage_limit);
	assign covers_header = (staged_base <= 19'd3) && (staged_sum > 20'd3);
	assign image_ok      = (ctx.staged_bytes >= cfg.min_image_bytes)
		&& (ctx.staged_bytes <= cfg.max_image_bytes)
		&& (ctx.image_byte_three == dfu_pkg::HEADER_MAGIC);

	always_comb begin
		ctx_next            = ctx;
		rsp                 = '0;
		rsp.reply_bytes     = dfu_pkg::REPLY_NONE;

		unique case (req.operation)
			dfu_pkg::OP_DNLOAD: begin
				if (req.payload_length != 16'd0) begin
					if (ctx.state != dfu_pkg::ST_IDLE && ctx.state != dfu_pkg::ST_DN_IDLE) begin
						ctx_next.status = dfu_pkg::STATUS_STALLED;
						ctx_next.state  = dfu_pkg::ST_FAULT;
						rsp.stalled     = 1'b1;
					end else begin
						if (fresh) begin
							ctx_next.staged_bytes     = '0;
							ctx_next.next_block       = '0;
							ctx_next.ready_flag       = 1'b0;
							ctx_next.image_byte_three = '0;
						end
						if (!block_ok || !size_ok) begin
							ctx_next.status = dfu_pkg::STATUS_ADDRESS;
							ctx_next.state  = dfu_pkg::ST_FAULT;
							rsp.stalled     = 1'b1;
						end else begin
							rsp.stage_write = 1'b1;
							rsp.stage_offset = staged_base[17:0];
							if (covers_header) begin
								ctx_next.image_byte_three = req.header_byte;
							end
							ctx_next.staged_bytes = staged_sum[18:0];
							ctx_next.next_block   = block_base + 19'd1;
							ctx_next.state        = dfu_pkg::ST_DN_SYNC;
						end
					end
				end else if (ctx.state != dfu_pkg::ST_DN_IDLE) begin
					ctx_next.status = dfu_pkg::STATUS_NOTDONE;
					ctx_next.state  = dfu_pkg::ST_FAULT;
					rsp.stalled     = 1'b1;
				end else begin
					ctx_next.state = dfu_pkg::ST_MAN_SYNC;
				end
			end
			dfu_pkg::OP_UPLOAD: begin
				rsp.stalled = 1'b1;
			end
			dfu_pkg::OP_GETSTATUS: begin
				rsp.reply_bytes = dfu_pkg::REPLY_GETSTATUS;
				if (ctx.state == dfu_pkg::ST_DN_SYNC) begin
					ctx_next.state = dfu_pkg::ST_DN_IDLE;
				end else if (ctx.state == dfu_pkg::ST_MAN_SYNC) begin
					if (image_ok) begin
						ctx_next.ready_flag = 1'b1;
						ctx_next.state      = dfu_pkg::ST_MAN;
						rsp.poll_timeout_ms = cfg.manifest_poll_ms;
					end else begin
						ctx_next.status = dfu_pkg::STATUS_FIRMWARE;
						ctx_next.state  = dfu_pkg::ST_FAULT;
					end
				end else if (ctx.state == dfu_pkg::ST_MAN) begin
					ctx_next.state = dfu_pkg::ST_MAN_WAIT;
				end
			end
			dfu_pkg::OP_CLRSTATUS: begin
				if (ctx.state == dfu_pkg::ST_FAULT) begin
					ctx_next.status = dfu_pkg::STATUS_OK;
					ctx_next.state  = dfu_pkg::ST_IDLE;
				end
			end
			dfu_pkg::OP_GETSTATE: begin
				rsp.reply_bytes = dfu_pkg::REPLY_GETSTATE;
			end
			dfu_pkg::OP_ABORT: begin
				if (ctx.state != dfu_pkg::ST_MAN && ctx.state != dfu_pkg::ST_MAN_WAIT) begin
					ctx_next.state        = dfu_pkg::ST_IDLE;
					ctx_next.staged_bytes = '0;
					ctx_next.next_block   = '0;
				end
			end
			dfu_pkg::OP_BUS_RESET: begin
				if (!ctx.ready_flag) begin
					ctx_next.state        = dfu_pkg::ST_IDLE;
					ctx_next.status       = dfu_pkg::STATUS_OK;
					ctx_next.staged_bytes = '0;
					ctx_next.next_block   = '0;
				end
			end
			dfu_pkg::OP_DETACH: begin
			end
		endcase

		rsp.reported_status = ctx_next.status;
		rsp.reported_state  = ctx_next.state;
		rsp.burn_pending    = ctx_next.ready_flag;
	end

endmodule

`default_nettype wire

// ===== src/dfu_download_state_machine_core.sv =====
// Device side of the DFU 1.1 download protocol, one class request per item.
// The req channel carries a request (or a bus reset) with its block number,
// length and the payload byte that would land at image offset 3. The rsp
// channel returns exactly one result per request: stall flag, status and state
// after the request, poll timeout, reply size, and the staging offset at which
// an outside memory is to store an accepted download payload.
// An accepted item is held in an input register; once the output register is
// empty or its result is being taken, the state is updated and the result is
// loaded into the output register, which drives rsp_valid. One request per
// cycle is sustained while rsp_ready is high. If the receiver stalls, the result
// waits in the output register and one more item may still be taken into the
// input register; further items wait on req_ready. The three configuration
// registers are written through cfg_we, cfg_index and cfg_data; the user must
// do so only while no request is in flight, as the block does not enforce it.
// Reset puts the block in the idle state with status ok, clears all counts,
// the image-ready flag and the header byte, empties both registers and loads
// the configuration defaults.
`default_nettype none

module dfu_download_state_machine_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             req_valid,
	output logic                                  req_ready,
	input  wire dfu_pkg::req_t                    req,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_ready,
	output dfu_pkg::rsp_t                         rsp,
	input  wire logic                             cfg_we,
	input  wire logic [dfu_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [dfu_pkg::CFG_DATA_W-1:0]   cfg_data
);

	dfu_pkg::cfg_t cfg;
	dfu_pkg::ctx_t ctx_q;
	dfu_pkg::ctx_t ctx_next;
	dfu_pkg::req_t req_s1;
	logic          valid_s1;
	dfu_pkg::rsp_t rsp_next;
	dfu_pkg::rsp_t rsp_s2;
	logic          valid_s2;
	logic          advance;

	dfu_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dfu_step u_step (
		.ctx      (ctx_q),
		.cfg      (cfg),
		.req      (req_s1),
		.ctx_next (ctx_next),
		.rsp      (rsp_next)
	);

	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.state            <= dfu_pkg::ST_IDLE;
			ctx_q.status           <= dfu_pkg::STATUS_OK;
			ctx_q.staged_bytes     <= '0;
			ctx_q.next_block       <= '0;
			ctx_q.ready_flag       <= 1'b0;
			ctx_q.image_byte_three <= '0;
		end else if (advance) begin
			ctx_q <= ctx_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_next;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	a_write_not_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.stage_write |->
			!rsp_s2.stalled && rsp_s2.reported_state == dfu_pkg::ST_DN_SYNC)
		else $error("accepted download block reported with wrong stall or state");

	a_poll_only_on_manifest: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.poll_timeout_ms != '0 |->
			rsp_s2.burn_pending && rsp_s2.reported_state == dfu_pkg::ST_MAN)
		else $error("poll timeout reported outside manifestation entry");

	a_ready_flag_states: assert property (@(posedge clk) disable iff (!arst_n)
		ctx_q.ready_flag |->
			ctx_q.state != dfu_pkg::ST_DN_SYNC && ctx_q.state != dfu_pkg::ST_DN_IDLE
			&& ctx_q.state != dfu_pkg::ST_MAN_SYNC)
		else $error("image ready flag set during a download");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2 && ctx_q == $past(ctx_next))
		else $error("state update and result register out of step");

endmodule

`default_nettype wire
